// File: rtl/wdtc_pkg.sv
// Package for the weigh-dose trickle controller.
// Field widths, constants and the divider request/response types.
// No dependencies.
`default_nettype none

package wdtc_pkg;

  localparam int MassW     = 20;
  localparam int TargetW   = 16;
  localparam int ElapsedW  = 8;
  localparam int MarginW   = 10;
  localparam int BandW     = 12;
  localparam int TimeW     = 16;
  localparam int ProgW     = 8;
  localparam int QuotW     = 7;   // quotient bits below the full-bar value
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int InDataW   = 48;
  localparam int OutDataW  = 16;

  localparam logic [TimeW-1:0] TimerMax = {TimeW{1'b1}};
  localparam logic [ProgW-1:0] BarFull  = 8'd128;

  localparam logic [MarginW-1:0] StopMarginRst  = 10'd4;
  localparam logic [BandW-1:0]   TrickleBandRst = 12'd100;
  localparam logic [TimeW-1:0]   SettleTimeRst  = 16'd2000;
  localparam logic [TimeW-1:0]   BumpTimeRst    = 16'd100;

  localparam logic [CfgIdxW-1:0] RegStopMargin  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTrickleBand = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSettleTime  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBumpTime    = 2'd3;

  typedef struct packed {
    logic               start;
    logic [TargetW-1:0] num;   // below den whenever start is set
    logic [TargetW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/wdtc_div.sv
// Shift-subtract divider for the progress bar: floor(num*128/den), num < den.
// One quotient bit per cycle, seven quotient bits in all. Uses wdtc_pkg.
`default_nettype none

module wdtc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wdtc_pkg::div_req_t req_i,
  output wdtc_pkg::div_rsp_t      rsp_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [2:0]                     cnt_q, cnt_d;
  logic [wdtc_pkg::TargetW-1:0]   rem_q, rem_d;
  logic [wdtc_pkg::TargetW-1:0]   den_q, den_d;
  logic [wdtc_pkg::QuotW-1:0]     quot_q, quot_d;
  logic [wdtc_pkg::TargetW:0]     shifted;
  logic                           fits;

  assign shifted = {rem_q, 1'b0};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 3'(wdtc_pkg::QuotW);
      rem_d  = req_i.num;
      den_d  = req_i.den;
      quot_d = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = wdtc_pkg::TargetW'(shifted - {1'b0, den_q});
      end else begin
        rem_d = shifted[wdtc_pkg::TargetW-1:0];
      end
      quot_d = {quot_q[wdtc_pkg::QuotW-2:0], fits};
      cnt_d  = cnt_q - 3'd1;
      if (cnt_q == 3'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

// File: rtl/weigh_dose_trickle_controller.sv
// Top level of the weigh-dose trickle controller.
// Sample sequencer, config registers and output register; uses wdtc_pkg, wdtc_div.
`default_nettype none

// Usage:
//   s_axis: one scale sample per beat. tdata = mass[19:0], target_weight[35:20],
//   elapsed_ms[43:36], cancel[44], zero padded to 48 bits.
//   m_axis: one result beat per sample. tdata = motor_on[0], running[1],
//   progress[9:2], zero padded to 16 bits; tlast = finished (run reached target).
//   cfg: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 stop_margin, 1 trickle_band, 2 settle_time, 3 bump_time). Write only
//   while idle.
//   Path: from the accepting edge through S_EVAL and S_OUT into the output
//   register that drives m_axis_tvalid; when the progress bar is computed,
//   S_DIV runs 7 quotient steps in the bit-serial divider and takes its result.
//   One sample is worked at a time; the next is taken only after it.
//   s_axis_tready is high whenever no sample is in work, also while a result
//   waits in the output register. A stalled receiver holds the result; the
//   next sample then waits in the final step until the register frees up.
//   Reset: run idle, motor off, timer saturated, progress 0, registers to
//   their defaults. No clearing pass.

module weigh_dose_trickle_controller (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // mass, target_weight, elapsed_ms, cancel (from bit 0 up)
  input  wire logic [wdtc_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // motor_on, running, progress (from bit 0 up)
  output logic [wdtc_pkg::OutDataW-1:0]        m_axis_tdata,
  output logic                                 m_axis_tlast,
  input  wire logic                            cfg_we_i,
  input  wire logic [wdtc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [wdtc_pkg::CfgDataW-1:0]   cfg_data_i
);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV, S_OUT} state_e;

  state_e state_q;

  logic [wdtc_pkg::MarginW-1:0]  stop_margin_q;
  logic [wdtc_pkg::BandW-1:0]    trickle_band_q;
  logic [wdtc_pkg::TimeW-1:0]    settle_time_q;
  logic [wdtc_pkg::TimeW-1:0]    bump_time_q;

  logic                          active_q, relay_q, settling_q, done_q;
  logic [wdtc_pkg::TimeW-1:0]    timer_q;
  logic [wdtc_pkg::ProgW-1:0]    prog_q;

  logic signed [wdtc_pkg::MassW-1:0] mass_q;
  logic [wdtc_pkg::TargetW-1:0]  target_q;
  logic [wdtc_pkg::ElapsedW-1:0] elapsed_q;
  logic                          cancel_q;

  logic                          out_valid_q, out_last_q;
  logic [wdtc_pkg::OutDataW-1:0] out_data_q;

  wdtc_pkg::div_req_t div_req;
  wdtc_pkg::div_rsp_t div_rsp;

  logic                          in_fire, out_free;
  logic [wdtc_pkg::TimeW:0]      timer_sum;
  logic [wdtc_pkg::TimeW-1:0]    timer_sat;
  logic signed [21:0]            mass_x, target_x, diff_x;
  logic                          reach, above_band;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  assign timer_sum = {1'b0, timer_q} + {9'd0, elapsed_q};
  assign timer_sat = timer_sum[wdtc_pkg::TimeW] ? wdtc_pkg::TimerMax
                                                 : timer_sum[wdtc_pkg::TimeW-1:0];

  assign mass_x     = 22'(mass_q);
  assign target_x   = {6'd0, target_q};
  assign diff_x     = target_x - mass_x;
  // mass >= target + margin, and target - mass > band
  assign reach      = diff_x <= -$signed({12'd0, stop_margin_q});
  assign above_band = diff_x > $signed({10'd0, trickle_band_q});

  assign div_req.num   = diff_x[wdtc_pkg::TargetW-1:0];
  assign div_req.den   = target_q;
  assign div_req.start = (state_q == S_EVAL) && active_q && !reach && !cancel_q
                         && above_band && (target_q != '0)
                         && (diff_x < target_x);

  wdtc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_margin_q  <= wdtc_pkg::StopMarginRst;
      trickle_band_q <= wdtc_pkg::TrickleBandRst;
      settle_time_q  <= wdtc_pkg::SettleTimeRst;
      bump_time_q    <= wdtc_pkg::BumpTimeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wdtc_pkg::RegStopMargin:  stop_margin_q  <= cfg_data_i[wdtc_pkg::MarginW-1:0];
        wdtc_pkg::RegTrickleBand: trickle_band_q <= cfg_data_i[wdtc_pkg::BandW-1:0];
        wdtc_pkg::RegSettleTime:  settle_time_q  <= cfg_data_i;
        wdtc_pkg::RegBumpTime:    bump_time_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mass_q    <= s_axis_tdata[19:0];
      target_q  <= s_axis_tdata[35:20];
      elapsed_q <= s_axis_tdata[43:36];
      cancel_q  <= s_axis_tdata[44];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      relay_q     <= 1'b0;
      settling_q  <= 1'b1;
      done_q      <= 1'b0;
      timer_q     <= wdtc_pkg::TimerMax;
      prog_q      <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          timer_q <= timer_sat;
          done_q  <= 1'b0;
          state_q <= S_OUT;
          if (!active_q) begin
            if (!cancel_q) begin
              active_q <= 1'b1;
              relay_q  <= 1'b1;
            end
          end else if (reach) begin
            relay_q  <= 1'b0;
            active_q <= 1'b0;
            done_q   <= 1'b1;
            prog_q   <= '0;
          end else if (cancel_q) begin
            relay_q  <= 1'b0;
            active_q <= 1'b0;
            prog_q   <= '0;
          end else if (above_band) begin
            relay_q <= 1'b1;
            if (target_q == '0) begin
              prog_q <= '0;
            end else if (diff_x >= target_x) begin
              prog_q <= wdtc_pkg::BarFull;
            end else begin
              state_q <= S_DIV;
            end
          end else if (settling_q) begin
            relay_q <= 1'b0;
            if (timer_sat >= settle_time_q) begin
              timer_q    <= '0;
              settling_q <= 1'b0;
            end
          end else begin
            relay_q <= 1'b1;
            if (timer_sat >= bump_time_q) begin
              timer_q    <= '0;
              settling_q <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            prog_q  <= {1'b0, div_rsp.quot};
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= done_q;
            out_data_q  <= {6'd0, prog_q, active_q, relay_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: sim/wdtc_dose_checker.sv
`timescale 1ns / 100ps
// Checker for the weigh-dose trickle controller: watches sample, result and config traffic,
// predicts each result from its own copy of the controller state and compares it.
// Depends on wdtc_pkg.

module wdtc_dose_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [wdtc_pkg::InDataW-1:0]    s_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [wdtc_pkg::OutDataW-1:0]   m_tdata_i,
  input  logic                            m_tlast_i,
  input  logic                            cfg_we_i,
  input  logic [wdtc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [wdtc_pkg::CfgDataW-1:0]   cfg_data_i,
  output int                              fail_cnt_o,
  output int                              pending_o
);

  typedef struct packed {
    logic                       motor_on;
    logic                       running;
    logic                       finished;
    logic [wdtc_pkg::ProgW-1:0] progress;
  } dose_result_t;

  logic [wdtc_pkg::MarginW-1:0] stop_margin;
  logic [wdtc_pkg::BandW-1:0]   trickle_band;
  logic [wdtc_pkg::TimeW-1:0]   settle_ms;
  logic [wdtc_pkg::TimeW-1:0]   bump_ms;

  logic                         run_active;
  logic                         relay_drive;
  logic                         in_settle;
  int unsigned                  phase_ms;
  logic [wdtc_pkg::ProgW-1:0]   held_progress;

  dose_result_t                 expected_q[$];
  int                           fails;

  function automatic logic [wdtc_pkg::ProgW-1:0] bar_fill(input longint tgt,
                                                          input longint mass);
    longint p;
    if (tgt <= 0) return '0;
    p = ((tgt - mass) * longint'(wdtc_pkg::BarFull)) / tgt;
    if (p < 0) p = 0;
    if (p > longint'(wdtc_pkg::BarFull)) p = longint'(wdtc_pkg::BarFull);
    return p[wdtc_pkg::ProgW-1:0];
  endfunction

  task predict_sample(input logic [wdtc_pkg::InDataW-1:0] beat, output dose_result_t res);
    longint      mass;
    longint      tgt;
    int unsigned el;
    logic        cxl;
    logic        done;
    mass = longint'($signed(beat[wdtc_pkg::MassW-1:0]));
    tgt  = longint'(beat[wdtc_pkg::MassW+wdtc_pkg::TargetW-1:wdtc_pkg::MassW]);
    el   = beat[wdtc_pkg::MassW+wdtc_pkg::TargetW+wdtc_pkg::ElapsedW-1:
                wdtc_pkg::MassW+wdtc_pkg::TargetW];
    cxl  = beat[wdtc_pkg::MassW+wdtc_pkg::TargetW+wdtc_pkg::ElapsedW];
    done = 1'b0;

    // timer runs on every sample, saturating
    phase_ms = phase_ms + el;
    if (phase_ms > wdtc_pkg::TimerMax) phase_ms = wdtc_pkg::TimerMax;

    if (!run_active) begin
      if (!cxl) begin
        run_active  = 1'b1;
        relay_drive = 1'b1;
      end
    end else if (mass >= tgt + longint'(stop_margin)) begin
      // reaching the target wins over a cancel on the same beat
      relay_drive   = 1'b0;
      run_active    = 1'b0;
      done          = 1'b1;
      held_progress = '0;
    end else if (cxl) begin
      relay_drive   = 1'b0;
      run_active    = 1'b0;
      held_progress = '0;
    end else if (tgt > mass + longint'(trickle_band)) begin
      relay_drive   = 1'b1;
      held_progress = bar_fill(tgt, mass);
    end else if (in_settle) begin
      relay_drive = 1'b0;
      if (phase_ms >= settle_ms) begin
        phase_ms  = 0;
        in_settle = 1'b0;
      end
    end else begin
      relay_drive = 1'b1;
      if (phase_ms >= bump_ms) begin
        phase_ms  = 0;
        in_settle = 1'b1;
      end
    end

    res.motor_on = relay_drive;
    res.running  = run_active;
    res.finished = done;
    res.progress = held_progress;
  endtask

  task check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    dose_result_t want;
    if (!rst_ni) begin
      stop_margin   = wdtc_pkg::StopMarginRst;
      trickle_band  = wdtc_pkg::TrickleBandRst;
      settle_ms     = wdtc_pkg::SettleTimeRst;
      bump_ms       = wdtc_pkg::BumpTimeRst;
      run_active    = 1'b0;
      relay_drive   = 1'b0;
      in_settle     = 1'b1;
      phase_ms      = wdtc_pkg::TimerMax;
      held_progress = '0;
      expected_q.delete();
      fails         = 0;
    end else begin
      // results first, so a beat never meets the prediction made on this same edge
      if (m_tvalid_i && m_tready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, got tdata %h tlast %b",
                   $time, m_tdata_i, m_tlast_i);
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("motor_on", want.motor_on, m_tdata_i[0]);
          check_field("running", want.running, m_tdata_i[1]);
          check_field("progress", want.progress, m_tdata_i[wdtc_pkg::ProgW+1:2]);
          check_field("finished", want.finished, m_tlast_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wdtc_pkg::RegStopMargin:  stop_margin  = cfg_data_i[wdtc_pkg::MarginW-1:0];
          wdtc_pkg::RegTrickleBand: trickle_band = cfg_data_i[wdtc_pkg::BandW-1:0];
          wdtc_pkg::RegSettleTime:  settle_ms    = cfg_data_i[wdtc_pkg::TimeW-1:0];
          wdtc_pkg::RegBumpTime:    bump_ms      = cfg_data_i[wdtc_pkg::TimeW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        predict_sample(s_tdata_i, want);
        expected_q.push_back(want);
      end
    end
    fail_cnt_o <= fails;
    pending_o  <= expected_q.size();
  end

endmodule

// File: sim/weigh_dose_trickle_controller_tb.sv
`timescale 1ns / 100ps
// Testbench top for weigh_dose_trickle_controller: clock, reset, sample and config stimulus,
// random result back-pressure and the verdict. Depends on wdtc_pkg and wdtc_dose_checker.

module weigh_dose_trickle_controller_tb;

  localparam int CycleLimit = 600000;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [wdtc_pkg::InDataW-1:0]    s_axis_tdata;   // mass, target_weight, elapsed_ms, cancel
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [wdtc_pkg::OutDataW-1:0]   m_axis_tdata;   // motor_on, running, progress
  logic                            m_axis_tlast;
  logic                            cfg_we_i;
  logic [wdtc_pkg::CfgIdxW-1:0]    cfg_idx_i;
  logic [wdtc_pkg::CfgDataW-1:0]   cfg_data_i;

  int                   fail_cnt;
  int                   pending;
  int                   cycle_cnt;
  int                   items_sent;
  int                   no_gap_left;
  logic                 rx_hold_req;
  int                   cur_margin;
  int                   cur_band;

  weigh_dose_trickle_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  wdtc_dose_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tlast_i  (m_axis_tlast),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("weigh_dose_trickle_controller_tb failed");
      $finish;
    end
  end

  // one sample beat; called and returning at a falling edge
  task send_sample(input int mass, input int tgt, input int el, input logic cxl);
    int gap;
    int r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) no_gap_left = 40;
      if (r < 50)      gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else             gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = '0;
    s_axis_tdata[wdtc_pkg::MassW-1:0] = mass[wdtc_pkg::MassW-1:0];
    s_axis_tdata[wdtc_pkg::MassW+wdtc_pkg::TargetW-1:wdtc_pkg::MassW] =
      tgt[wdtc_pkg::TargetW-1:0];
    s_axis_tdata[wdtc_pkg::MassW+wdtc_pkg::TargetW+wdtc_pkg::ElapsedW-1:
                 wdtc_pkg::MassW+wdtc_pkg::TargetW] = el[wdtc_pkg::ElapsedW-1:0];
    s_axis_tdata[wdtc_pkg::MassW+wdtc_pkg::TargetW+wdtc_pkg::ElapsedW] = cxl;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task write_reg(input logic [wdtc_pkg::CfgIdxW-1:0] idx, input int val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val[wdtc_pkg::CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task set_config(input int margin, input int band, input int settle, input int bump);
    write_reg(wdtc_pkg::RegStopMargin, margin);
    write_reg(wdtc_pkg::RegTrickleBand, band);
    write_reg(wdtc_pkg::RegSettleTime, settle);
    write_reg(wdtc_pkg::RegBumpTime, bump);
    cur_margin = margin;
    cur_band   = band;
  endtask

  // sender holds off until every result is back
  task drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  function automatic int rand_elapsed();
    if ($urandom_range(0, 99) < 40) return $urandom_range(0, 20);
    return $urandom_range(0, 255);
  endfunction

  // start, coarse approach, trickle approach, finish; cancel now and then
  task dose_run();
    int   tgt;
    int   ramp;
    int   steps;
    int   r;
    logic cxl;
    r = $urandom_range(0, 99);
    if (r < 5)       tgt = 0;
    else if (r < 10) tgt = 65535;
    else if (r < 20) tgt = $urandom_range(0, 65535);
    else             tgt = $urandom_range(200, 6000);
    ramp = $urandom_range(0, cur_band + 3000);
    send_sample(tgt - ramp, tgt, rand_elapsed(), 1'b0);
    steps = 0;
    while (ramp > -cur_margin && steps < 40) begin
      if (ramp > cur_band) ramp -= $urandom_range(1, (ramp - cur_band) / 2 + 1);
      else                 ramp -= $urandom_range(0, cur_band / 8 + 3);
      cxl = ($urandom_range(0, 99) < 3);
      send_sample(tgt - ramp, tgt, rand_elapsed(), cxl);
      if (cxl) return;
      steps++;
    end
    if (ramp > -cur_margin)
      send_sample(tgt + cur_margin + $urandom_range(0, 2), tgt, rand_elapsed(),
                  $urandom_range(0, 9) == 0);
  endtask

  task run_phase(input int n_items);
    int end_at;
    end_at = items_sent + n_items;
    while (items_sent < end_at) begin
      if ($urandom_range(0, 99) < 15)
        send_sample($urandom, $urandom, $urandom, $urandom_range(0, 1));
      else
        dose_run();
    end
  endtask

  // receiver: random ready pattern, plus one long hold-off on request
  initial begin : receiver
    int r;
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          m_axis_tready = 1'b1;
          n = $urandom_range(30, 80);
        end else if (r < 60) begin
          m_axis_tready = 1'b1;
          n = $urandom_range(1, 6);
        end else if (r < 95) begin
          m_axis_tready = 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          m_axis_tready = 1'b0;
          n = $urandom_range(20, 60);
        end
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    items_sent    = 0;
    no_gap_left   = 0;
    rx_hold_req   = 1'b0;
    cur_margin    = wdtc_pkg::StopMarginRst;
    cur_band      = wdtc_pkg::TrickleBandRst;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed, reset register values
    send_sample(0, 1000, 0, 1'b1);          // cancel while idle
    send_sample(0, 1000, 0, 1'b0);          // start
    send_sample(0, 1000, 10, 1'b0);         // full bar
    send_sample(500, 1000, 10, 1'b0);       // half bar
    send_sample(-524288, 65535, 255, 0);    // most negative mass, saturated bar
    send_sample(-1000, 0, 1, 1'b0);         // zero target above band
    send_sample(950, 1000, 255, 1'b0);      // in band, saturated timer ends settle
    send_sample(960, 1000, 50, 1'b0);       // bump
    send_sample(970, 1000, 60, 1'b0);       // bump ends
    send_sample(980, 1000, 255, 1'b0);      // settle
    send_sample(1004, 1000, 0, 1'b1);       // reached together with cancel
    send_sample(0, 1000, 0, 1'b0);
    send_sample(100, 1000, 0, 1'b1);        // cancel in a run
    send_sample(0, 1000, 0, 1'b1);
    send_sample(524287, 0, 255, 1'b0);      // start, largest mass
    send_sample(524287, 0, 255, 1'b0);      // finish
    send_sample(0, 65535, 255, 1'b1);
    send_sample(0, 65535, 0, 1'b0);
    send_sample(65538, 65535, 0, 1'b0);     // one below stop point
    send_sample(65539, 65535, 0, 1'b0);     // exactly at stop point
    drain();

    set_config(0, 0, 0, 0);
    run_phase(200);
    drain();

    set_config(1023, 4095, 65535, 65535);
    run_phase(200);
    drain();

    set_config($urandom_range(0, 50), $urandom_range(50, 800),
               $urandom_range(0, 1500), $urandom_range(0, 400));
    run_phase(100);
    rx_hold_req = 1'b1;
    no_gap_left = 60;
    run_phase(100);
    drain();

    set_config($urandom_range(0, 1023), $urandom_range(0, 4095),
               $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_phase(200);
    drain();

    set_config(wdtc_pkg::StopMarginRst, wdtc_pkg::TrickleBandRst,
               wdtc_pkg::SettleTimeRst, wdtc_pkg::BumpTimeRst);
    run_phase(200);
    drain();

    if (fail_cnt == 0)
      $display("weigh_dose_trickle_controller_tb passed");
    else
      $display("weigh_dose_trickle_controller_tb failed");
    $finish;
  end

endmodule
